// ===== sv/cpr_pkg.sv =====
// Shared constants, types and helpers of the clock page replacement block.
`default_nettype none

package cpr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    // frame index width and a count width that holds FRAMES and any 4-bit register value
    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(((FRAMES > 15) ? FRAMES : 15) + 1);
    localparam int CFG_W  = 4;
    localparam int HIT_W  = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic look;   // search cycle: first matching cell sets its ref bit
        logic fix;    // miss seen: pull a stray hand back to frame 0
        logic sweep;  // hand step: clear a set bit or load the page
    } cell_ctrl_t;

    // result frame field is 3 bits wide whatever the index width
    function automatic logic [2:0] frame_field(input logic [FIDX_W-1:0] idx);
        logic [FIDX_W+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/cpr_cell.sv =====
// One page frame of the clock: page tag, valid and reference bits, and its share of the hand.
`default_nettype none

module cpr_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          first,
    input  wire logic                          active,
    input  wire logic                          last,
    input  wire logic [cpr_pkg::PAGE_BITS-1:0] page_i,
    input  wire cpr_pkg::cell_ctrl_t           ctrl,
    input  wire logic                          hit_in,
    output logic                               hit_out,
    output logic                               sel,
    input  wire logic                          tok_in,
    output logic                               tok_out,
    output logic                               tok,
    output logic                               refb
);

    logic [cpr_pkg::PAGE_BITS-1:0] page_reg;
    logic                          valid_reg, valid_next;
    logic                          refb_reg, refb_next;
    logic                          tok_reg, tok_next;
    logic                          load;
    logic                          match;

    assign match   = valid_reg && active && (page_reg == page_i);
    assign hit_out = hit_in | match;
    assign sel     = match & ~hit_in;
    // hand moves to the neighbor; the last active frame hands back to frame 0 via the top
    assign tok_out = ctrl.sweep & tok_reg & ~last;
    assign tok     = tok_reg;
    assign refb    = refb_reg;

    always_comb begin
        valid_next = valid_reg;
        refb_next  = refb_reg;
        tok_next   = tok_reg;
        load       = 1'b0;
        if (ctrl.look && sel) begin
            refb_next = 1'b1;
        end
        if (ctrl.fix) begin
            tok_next = (tok_reg & active) | tok_in;
        end
        if (ctrl.sweep) begin
            tok_next = tok_in;
            if (tok_reg) begin
                if (refb_reg) begin
                    refb_next = 1'b0;
                end else begin
                    load       = 1'b1;
                    valid_next = 1'b1;
                    refb_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            refb_reg  <= 1'b0;
            tok_reg   <= first;
        end else begin
            valid_reg <= valid_next;
            refb_reg  <= refb_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            page_reg <= page_i;
        end
    end

endmodule

`default_nettype wire

// ===== sv/clock_page_replacement_top.sv =====
// Top level of the clock (second-chance) page replacement block.
// Usage:
//   s_valid/s_ready/s_page carry one page reference per item. m_valid/m_ready
//   carry one result item per reference: hit flag, frame now holding the page,
//   and the saturating hit and fault counts including this reference.
//   cfg_valid/cfg_ready/cfg_data write frames_in_use; write it only while idle.
// Timing:
//   The block handles one item at a time. A hit passes through search, emit
//   and idle before the next accept. A miss adds one hand step per frame
//   the hand visits: one for each set reference bit the hand clears, at
//   most the managed frame count, and one that loads the page. The hand is a
//   one-hot token stepped down the row of frame cells, one cell per cycle.
// Reset:
//   aresetn (synchronous, active low) empties all frames, clears reference
//   bits, puts the hand on frame 0, zeroes both counters and sets
//   frames_in_use to 8. No clearing pass is needed.
// Stall:
//   A result waits in the output register while m_ready is low; the block
//   holds the next finished item until that register frees.
`default_nettype none

module clock_page_replacement_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [cpr_pkg::PAGE_BITS-1:0]   s_page,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_hit,
    output logic [2:0]                           m_frame,
    output logic [cpr_pkg::HIT_W-1:0]            m_hit_count,
    output logic [cpr_pkg::HIT_W-1:0]            m_fault_count,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cpr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int N = cpr_pkg::FRAMES;

    cpr_pkg::state_t                 state_reg, state_next;
    logic [cpr_pkg::CFG_W-1:0]       fiu_reg;
    logic [cpr_pkg::PAGE_BITS-1:0]   page_reg;
    logic [cpr_pkg::HIT_W-1:0]       hits_reg, hits_next;
    logic [cpr_pkg::HIT_W-1:0]       faults_reg, faults_next;
    logic                            pend_hit_reg, pend_hit_next;
    logic [cpr_pkg::FIDX_W-1:0]      pend_frame_reg, pend_frame_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            m_hit_reg;
    logic [2:0]                      m_frame_reg;
    logic [cpr_pkg::HIT_W-1:0]       m_hit_count_reg;
    logic [cpr_pkg::HIT_W-1:0]       m_fault_count_reg;
    logic                            emit;

    cpr_pkg::cell_ctrl_t             ctrl;
    logic [cpr_pkg::CNT_W-1:0]       n_act;
    logic [N-1:0]                    active, last, hit_in, hit_out, sel;
    logic [N-1:0]                    tok_in, tok_out, tok, refb;
    logic                            any_hit, stray, wrapped, cur_ref;
    logic [cpr_pkg::FIDX_W-1:0]      sel_idx, tok_idx;

    // effective frame count: zero acts as one, oversize clamps to FRAMES
    always_comb begin
        n_act = cpr_pkg::CNT_W'(fiu_reg);
        if (n_act == '0) begin
            n_act = cpr_pkg::CNT_W'(1);
        end else if (n_act > cpr_pkg::CNT_W'(N)) begin
            n_act = cpr_pkg::CNT_W'(N);
        end
    end

    // row of frame cells; hit priority ripples from frame 0 upward
    for (genvar i = 0; i < N; i++) begin : g_cell
        assign active[i] = cpr_pkg::CNT_W'(i) < n_act;
        assign last[i]   = cpr_pkg::CNT_W'(i + 1) == n_act;
        if (i == 0) begin : g_head
            assign hit_in[i] = 1'b0;
            assign tok_in[i] = ctrl.fix ? stray : (ctrl.sweep & wrapped);
        end else begin : g_body
            assign hit_in[i] = hit_out[i-1];
            assign tok_in[i] = tok_out[i-1];
        end

        cpr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .first   (i == 0),
            .active  (active[i]),
            .last    (last[i]),
            .page_i  (page_reg),
            .ctrl    (ctrl),
            .hit_in  (hit_in[i]),
            .hit_out (hit_out[i]),
            .sel     (sel[i]),
            .tok_in  (tok_in[i]),
            .tok_out (tok_out[i]),
            .tok     (tok[i]),
            .refb    (refb[i])
        );
    end

    assign any_hit = hit_out[N-1];
    assign stray   = |(tok & ~active);   // hand left beyond a shrunk frame count
    assign wrapped = |(tok & last);      // hand leaves the last active frame
    assign cur_ref = |(tok & refb);      // reference bit under the hand

    // one-hot to index for the matching frame and the hand
    always_comb begin
        sel_idx = '0;
        tok_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (sel[i]) begin
                sel_idx = sel_idx | cpr_pkg::FIDX_W'(i);
            end
            if (tok[i]) begin
                tok_idx = tok_idx | cpr_pkg::FIDX_W'(i);
            end
        end
    end

    assign emit = (state_reg == cpr_pkg::ST_EMIT) && (!m_valid_reg || m_ready);

    // sequencer: idle, search, hand sweep, emit
    always_comb begin
        state_next      = state_reg;
        ctrl            = '0;
        s_ready         = 1'b0;
        hits_next       = hits_reg;
        faults_next     = faults_reg;
        pend_hit_next   = pend_hit_reg;
        pend_frame_next = pend_frame_reg;
        unique case (state_reg)
            cpr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = cpr_pkg::ST_LOOK;
                end
            end
            cpr_pkg::ST_LOOK: begin
                ctrl.look = 1'b1;
                if (any_hit) begin
                    pend_hit_next   = 1'b1;
                    pend_frame_next = sel_idx;
                    if (hits_reg != '1) begin
                        hits_next = hits_reg + 1'b1;
                    end
                    state_next = cpr_pkg::ST_EMIT;
                end else begin
                    ctrl.fix   = 1'b1;
                    state_next = cpr_pkg::ST_SWEEP;
                end
            end
            cpr_pkg::ST_SWEEP: begin
                ctrl.sweep = 1'b1;
                if (!cur_ref) begin
                    pend_hit_next   = 1'b0;
                    pend_frame_next = tok_idx;
                    if (faults_reg != '1) begin
                        faults_next = faults_reg + 1'b1;
                    end
                    state_next = cpr_pkg::ST_EMIT;
                end
            end
            cpr_pkg::ST_EMIT: begin
                if (emit) begin
                    state_next = cpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cpr_pkg::ST_IDLE;
            fiu_reg     <= cpr_pkg::CFG_W'(8);
            hits_reg    <= '0;
            faults_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hits_reg    <= hits_next;
            faults_reg  <= faults_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                fiu_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_hit_reg   <= pend_hit_next;
        pend_frame_reg <= pend_frame_next;
        if (s_valid && s_ready) begin
            page_reg <= s_page;
        end
        if (emit) begin
            m_hit_reg         <= pend_hit_reg;
            m_frame_reg       <= cpr_pkg::frame_field(pend_frame_reg);
            m_hit_count_reg   <= hits_reg;
            m_fault_count_reg <= faults_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_frame       = m_frame_reg;
    assign m_hit_count   = m_hit_count_reg;
    assign m_fault_count = m_fault_count_reg;

`ifndef ASSERT_OFF
    // the hand is always exactly one frame
    a_hand_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(tok))
        else $error("clock hand is not one-hot");

    // during a sweep the hand sits inside the managed frames
    a_hand_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cpr_pkg::ST_SWEEP) |-> (|(tok & active)))
        else $error("clock hand outside active frames during sweep");

    // a reported hit has been counted
    a_hit_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (m_hit_count != '0))
        else $error("hit reported with zero hit count");
`endif

endmodule

`default_nettype wire
